>>> rtl/sfs_pkg.sv
package sfs_pkg;

  localparam int unsigned DriveWidth = 16;
  localparam int unsigned CfgWidth   = 16;

  localparam logic [2:0] OP_SHOOT       = 3'd0;
  localparam logic [2:0] OP_PRELOAD     = 3'd1;
  localparam logic [2:0] OP_NOT_SHOOTING = 3'd2;
  localparam logic [2:0] OP_HOLD_SPEED  = 3'd3;
  localparam logic [2:0] OP_ALL_OFF     = 3'd4;

  localparam logic [1:0] LIFT_OFF     = 2'd0;
  localparam logic [1:0] LIFT_FORWARD = 2'd1;
  localparam logic [1:0] LIFT_REVERSE = 2'd2;

  localparam logic [1:0] REG_LOOP_GAIN      = 2'd0;
  localparam logic [1:0] REG_CLEAR_TICKS    = 2'd1;
  localparam logic [1:0] REG_SPINUP_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_REVERSE_DRIVE  = 2'd3;

  localparam logic [15:0] Q15_FULL       = 16'h7FFF;
  localparam logic [18:0] PRELOAD_LIMIT  = 19'd32768;

  typedef struct packed {
    logic [2:0]  operation;
    logic [14:0] target_speed;
    logic [15:0] measured_speed;
  } tick_t;

  typedef struct packed {
    logic [1:0]         lift_command;
    logic signed [15:0] shooter_drive;
    logic               up_to_speed;
    logic               path_clear;
  } result_t;

  typedef struct packed {
    logic [15:0] loop_gain;
    logic [15:0] clear_ticks;
    logic [15:0] spinup_timeout_ticks;
    logic [15:0] reverse_drive;
  } cfg_t;

  typedef struct packed {
    logic        speed_reached;
    logic        clear_flag;
    logic [14:0] previous_target;
    logic [1:0]  lift_state;
    logic [15:0] drive_level;
  } seq_state_t;

endpackage

>>> rtl/sfs_step.sv
module sfs_step #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  sfs_pkg::cfg_t       cfg,
  input  sfs_pkg::tick_t      tick,
  input  sfs_pkg::seq_state_t cur,
  input  logic [TICK_WIDTH-1:0] tick_count,
  output sfs_pkg::seq_state_t nxt,
  output logic [TICK_WIDTH-1:0] tick_count_next,
  output sfs_pkg::result_t    res
);

  localparam int unsigned CmpWidth = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

  logic [15:0] err;
  logic [30:0] product;
  logic [23:0] drive_sum;
  logic [15:0] loop_drive;
  logic [18:0] measured_x5;
  logic [18:0] target_x4;
  logic        below_target;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic [CmpWidth-1:0] tick_ext;
  logic [CmpWidth-1:0] inc_ext;
  logic [CmpWidth-1:0] clear_ext;
  logic [CmpWidth-1:0] timeout_ext;
  logic        reached;

  always_comb begin
    if ({1'b0, tick.target_speed} > tick.measured_speed) begin
      err = {1'b0, tick.target_speed} - tick.measured_speed;
    end else begin
      err = '0;
    end
    product   = 31'(cfg.loop_gain * err[14:0]);
    drive_sum = 24'(tick.target_speed) + 24'(product[30:8]);
    if (drive_sum > 24'(sfs_pkg::Q15_FULL)) begin
      loop_drive = sfs_pkg::Q15_FULL;
    end else begin
      loop_drive = drive_sum[15:0];
    end
  end

  assign measured_x5  = 19'(tick.measured_speed) * 19'd5;
  assign target_x4    = {2'b00, tick.target_speed, 2'b00};
  assign below_target = measured_x5 < target_x4;
  assign tick_inc     = tick_count + TICK_WIDTH'(1);
  assign tick_ext     = CmpWidth'(tick_count);
  assign inc_ext      = CmpWidth'(tick_inc);
  assign clear_ext    = CmpWidth'(cfg.clear_ticks);
  assign timeout_ext  = CmpWidth'(cfg.spinup_timeout_ticks);

  always_comb begin
    nxt             = cur;
    tick_count_next = tick_count;
    reached         = cur.speed_reached;
    case (tick.operation)
      sfs_pkg::OP_SHOOT: begin
        if (cur.previous_target != tick.target_speed) begin
          reached = 1'b0;
        end
        if (!cur.clear_flag) begin
          if (inc_ext < clear_ext) begin
            tick_count_next = tick_inc;
            nxt.lift_state  = sfs_pkg::LIFT_REVERSE;
            nxt.drive_level = cfg.reverse_drive;
          end else begin
            tick_count_next = '0;
            nxt.lift_state  = sfs_pkg::LIFT_OFF;
            nxt.clear_flag  = 1'b1;
            reached         = 1'b0;
          end
          nxt.previous_target = '0;
        end else begin
          nxt.drive_level     = loop_drive;
          nxt.previous_target = tick.target_speed;
          if (!reached) begin
            if (below_target && (tick_ext < timeout_ext)) begin
              tick_count_next = tick_inc;
            end else begin
              tick_count_next = '0;
              reached         = 1'b1;
            end
          end else begin
            nxt.lift_state = sfs_pkg::LIFT_FORWARD;
          end
        end
        nxt.speed_reached = reached;
      end
      sfs_pkg::OP_PRELOAD: begin
        nxt.drive_level   = '0;
        nxt.speed_reached = 1'b0;
        if (measured_x5 <= sfs_pkg::PRELOAD_LIMIT) begin
          nxt.lift_state = sfs_pkg::LIFT_FORWARD;
          nxt.clear_flag = 1'b0;
        end else begin
          nxt.lift_state = sfs_pkg::LIFT_OFF;
        end
      end
      sfs_pkg::OP_NOT_SHOOTING: begin
        tick_count_next = '0;
        nxt.lift_state  = sfs_pkg::LIFT_OFF;
      end
      sfs_pkg::OP_HOLD_SPEED: begin
        nxt.drive_level = loop_drive;
      end
      sfs_pkg::OP_ALL_OFF: begin
        nxt.lift_state  = sfs_pkg::LIFT_OFF;
        nxt.drive_level = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    res.lift_command  = nxt.lift_state;
    res.shooter_drive = nxt.drive_level;
    res.up_to_speed   = nxt.speed_reached;
    res.path_clear    = nxt.clear_flag;
  end

endmodule

>>> rtl/shooter_feed_sequencer_unit.sv
// Shooter and ball-lift sequencer, one transfer per control tick.
// Tick channel (tick_valid/tick_stall/tick_data): operation, target speed and
// measured flywheel speed. Result channel (result_valid/result_stall/
// result_data): lift command, shooter drive and the spin-up and path flags,
// one result per tick, in order.
// Configuration: cfg_write with cfg_index/cfg_data writes loop gain, clear
// ticks, spin-up timeout and reverse drive; write only while no tick is in
// flight.
// Path: a taken tick is registered in the input register; the speed-loop
// multiply and sequencing then load the result register, from which the
// result transfers. Throughput: one tick per cycle while the result side
// takes them.
// A stalled result holds; the input register keeps taking a tick while the
// result waits, and tick_stall rises only when both registers are full.
// Reset: configuration returns to gain 1.0, 25 clear ticks, timeout 100 and
// zero reverse drive; lift off, drive zero, path marked clear, counter zero.
module shooter_feed_sequencer_unit #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  sfs_pkg::tick_t    tick_data,
  output logic              result_valid,
  input  logic              result_stall,
  output sfs_pkg::result_t  result_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [sfs_pkg::CfgWidth-1:0] cfg_data
);

  sfs_pkg::cfg_t       cfg;
  sfs_pkg::seq_state_t state;
  sfs_pkg::seq_state_t state_next;
  logic [TICK_WIDTH-1:0] tick_count;
  logic [TICK_WIDTH-1:0] tick_count_next;
  sfs_pkg::tick_t      held_tick;
  logic                held_valid;
  sfs_pkg::result_t    step_result;
  logic                advance;

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign tick_stall = held_valid && !advance;

  sfs_step #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_step (
    .cfg            (cfg),
    .tick           (held_tick),
    .cur            (state),
    .tick_count     (tick_count),
    .nxt            (state_next),
    .tick_count_next(tick_count_next),
    .res            (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_gain            <= 16'd256;
      cfg.clear_ticks          <= 16'd25;
      cfg.spinup_timeout_ticks <= 16'd100;
      cfg.reverse_drive        <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        sfs_pkg::REG_LOOP_GAIN:      cfg.loop_gain            <= cfg_data;
        sfs_pkg::REG_CLEAR_TICKS:    cfg.clear_ticks          <= cfg_data;
        sfs_pkg::REG_SPINUP_TIMEOUT: cfg.spinup_timeout_ticks <= cfg_data;
        sfs_pkg::REG_REVERSE_DRIVE:  cfg.reverse_drive        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid          <= 1'b0;
      result_valid        <= 1'b0;
      tick_count          <= '0;
      state.speed_reached <= 1'b0;
      state.clear_flag    <= 1'b1;
      state.previous_target <= '0;
      state.lift_state    <= sfs_pkg::LIFT_OFF;
      state.drive_level   <= '0;
    end else begin
      if (tick_valid && !tick_stall) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        state        <= state_next;
        tick_count   <= tick_count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      held_tick <= tick_data;
    end
    if (advance) begin
      result_data <= step_result;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned TickBits = 16;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    sfs_pkg::tick_t   stim;
    bit               typed;
    sfs_pkg::result_t want;
  } script_row_t;

  logic                         clk;
  logic                         rst;
  logic                         tick_valid;
  logic                         tick_stall;
  sfs_pkg::tick_t               tick_data;
  logic                         result_valid;
  logic                         result_stall;
  sfs_pkg::result_t             result_data;
  logic                         cfg_write;
  logic [1:0]                   cfg_index;
  logic [sfs_pkg::CfgWidth-1:0] cfg_data;

  shooter_feed_sequencer_unit #(.TICK_WIDTH(TickBits)) dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick_data    (tick_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  logic [15:0]         gain_q88;
  logic [15:0]         clear_len;
  logic [15:0]         spinup_limit;
  logic [15:0]         reverse_level;

  logic [TickBits-1:0] seq_ticks;
  logic                seq_reached;
  logic                seq_clear;
  logic [14:0]         seq_prev_target;
  logic [1:0]          seq_lift;
  logic [15:0]         seq_drive;

  sfs_pkg::result_t owed_commands[$];
  script_row_t      opening_script[$];
  int               error_count;
  int               ticks_counted;
  int               results_taken;
  bit               idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [15:0] loop_drive(input logic [14:0] target,
                                             input logic [15:0] measured);
    logic [47:0] drive;
    logic [15:0] shortfall;
    drive = 48'(target);
    if ({1'b0, target} > measured) begin
      shortfall = {1'b0, target} - measured;
      drive = drive + ((48'(gain_q88) * 48'(shortfall)) >> 8);
    end
    if (drive > 48'(sfs_pkg::Q15_FULL)) drive = 48'(sfs_pkg::Q15_FULL);
    return drive[15:0];
  endfunction

  function automatic sfs_pkg::result_t advance_sequencer(input sfs_pkg::tick_t t);
    logic [31:0]      meas5;
    logic [31:0]      targ4;
    sfs_pkg::result_t r;
    meas5 = 32'(t.measured_speed) * 32'd5;
    targ4 = 32'(t.target_speed) * 32'd4;
    case (t.operation)
      sfs_pkg::OP_SHOOT: begin
        if (seq_prev_target != t.target_speed) seq_reached = 1'b0;
        if (!seq_clear) begin
          seq_ticks = seq_ticks + TickBits'(1);
          if (seq_ticks < clear_len) begin
            seq_lift  = sfs_pkg::LIFT_REVERSE;
            seq_drive = reverse_level;
          end else begin
            seq_lift    = sfs_pkg::LIFT_OFF;
            seq_ticks   = '0;
            seq_clear   = 1'b1;
            seq_reached = 1'b0;
          end
          seq_prev_target = '0;
        end else begin
          seq_drive       = loop_drive(t.target_speed, t.measured_speed);
          seq_prev_target = t.target_speed;
          if (!seq_reached) begin
            if (meas5 < targ4 && seq_ticks < spinup_limit) begin
              seq_ticks = seq_ticks + TickBits'(1);
            end else begin
              seq_ticks   = '0;
              seq_reached = 1'b1;
            end
          end else begin
            seq_lift = sfs_pkg::LIFT_FORWARD;
          end
        end
      end
      sfs_pkg::OP_PRELOAD: begin
        seq_lift    = sfs_pkg::LIFT_OFF;
        seq_drive   = '0;
        seq_reached = 1'b0;
        if (meas5 <= 32'(sfs_pkg::PRELOAD_LIMIT)) begin
          seq_lift  = sfs_pkg::LIFT_FORWARD;
          seq_clear = 1'b0;
        end
      end
      sfs_pkg::OP_NOT_SHOOTING: begin
        seq_ticks = '0;
        seq_lift  = sfs_pkg::LIFT_OFF;
      end
      sfs_pkg::OP_HOLD_SPEED: seq_drive = loop_drive(t.target_speed, t.measured_speed);
      sfs_pkg::OP_ALL_OFF: begin
        seq_lift  = sfs_pkg::LIFT_OFF;
        seq_drive = '0;
      end
      default: ;
    endcase
    r.lift_command  = seq_lift;
    r.shooter_drive = seq_drive;
    r.up_to_speed   = seq_reached;
    r.path_clear    = seq_clear;
    return r;
  endfunction

  function automatic sfs_pkg::tick_t make_tick(input logic [2:0] op,
                                               input logic [14:0] target,
                                               input logic [15:0] measured);
    sfs_pkg::tick_t t;
    t.operation      = op;
    t.target_speed   = target;
    t.measured_speed = measured;
    return t;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [14:0] target,
                                  input logic [15:0] measured, input bit typed,
                                  input logic [1:0] lift, input logic [15:0] drive,
                                  input logic up, input logic clr);
    script_row_t row;
    row.stim                = make_tick(op, target, measured);
    row.typed               = typed;
    row.want.lift_command   = lift;
    row.want.shooter_drive  = drive;
    row.want.up_to_speed    = up;
    row.want.path_clear     = clr;
    opening_script.push_back(row);
  endfunction

  function automatic logic [14:0] pick_speed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 15'h7FFF;
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic sfs_pkg::tick_t noise_tick();
    return make_tick(3'($urandom), 15'($urandom), 16'($urandom));
  endfunction

  task automatic send_tick(input sfs_pkg::tick_t t, input bit typed = 1'b0,
                           input sfs_pkg::result_t want = '0);
    sfs_pkg::result_t predicted;
    while (idle_on && $urandom_range(99) < 25) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    predicted = advance_sequencer(t);
    owed_commands.push_back(typed ? want : predicted);
    if (t.operation <= sfs_pkg::OP_ALL_OFF) ticks_counted++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    tick_valid <= 1'b0;
    while (owed_commands.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] gain, input logic [15:0] clr,
                               input logic [15:0] spin, input logic [15:0] rev);
    write_reg(sfs_pkg::REG_LOOP_GAIN, gain);
    write_reg(sfs_pkg::REG_CLEAR_TICKS, clr);
    write_reg(sfs_pkg::REG_SPINUP_TIMEOUT, spin);
    write_reg(sfs_pkg::REG_REVERSE_DRIVE, rev);
    cfg_write     <= 1'b0;
    gain_q88      = gain;
    clear_len     = clr;
    spinup_limit  = spin;
    reverse_level = rev;
  endtask

  // preload, then a spin-up run with a rising measured speed; at times noise ticks only
  task automatic play_session();
    logic [14:0] goal;
    int          meas;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 12)) send_tick(noise_tick());
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_tick(make_tick(sfs_pkg::OP_PRELOAD, pick_speed(),
                            $urandom_range(1) ? 16'($urandom_range(0, 6554)) : 16'($urandom)));
      end
      goal = pick_speed();
      meas = 0;
      repeat ($urandom_range(3, 60)) begin
        case ($urandom_range(15))
          0: send_tick(noise_tick());
          1: goal = pick_speed();
          default: begin
            meas = meas + $urandom_range(0, int'(goal) / 4 + 64);
            if (meas > 65535) meas = 65535;
            send_tick(make_tick(sfs_pkg::OP_SHOOT, goal, 16'(meas)));
          end
        endcase
      end
    end
  endtask

  task automatic play_phase(input int count);
    int stop;
    stop = ticks_counted + count;
    while (ticks_counted < stop) play_session();
    wait_drained();
  endtask

  task automatic check_result(input sfs_pkg::result_t got);
    sfs_pkg::result_t want;
    if (owed_commands.size() == 0) begin
      $error("result transfer with no tick outstanding: %p", got);
      error_count++;
    end else begin
      want = owed_commands.pop_front();
      if (got.lift_command !== want.lift_command) begin
        $error("lift_command: expected %0d, got %0d", want.lift_command, got.lift_command);
        error_count++;
      end
      if (got.shooter_drive !== want.shooter_drive) begin
        $error("shooter_drive: expected %0d, got %0d", want.shooter_drive,
               got.shooter_drive);
        error_count++;
      end
      if (got.up_to_speed !== want.up_to_speed) begin
        $error("up_to_speed: expected %0b, got %0b", want.up_to_speed, got.up_to_speed);
        error_count++;
      end
      if (got.path_clear !== want.path_clear) begin
        $error("path_clear: expected %0b, got %0b", want.path_clear, got.path_clear);
        error_count++;
      end
    end
  endtask

  initial begin
    int  hold_left;
    bit  held_once;
    hold_left = 0;
    held_once = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        check_result(result_data);
        results_taken++;
      end
      if (!held_once && results_taken >= 700 && tick_valid) begin
        hold_left = 300;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= idle_on && ($urandom_range(99) < 25);
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    tick_valid <= 1'b0;
    tick_data  <= '0;
    cfg_write  <= 1'b0;
    cfg_index  <= sfs_pkg::REG_LOOP_GAIN;
    cfg_data   <= '0;
    error_count     = 0;
    ticks_counted   = 0;
    results_taken   = 0;
    idle_on         = 1'b1;
    gain_q88        = 16'd256;
    clear_len       = 16'd25;
    spinup_limit    = 16'd100;
    reverse_level   = 16'd0;
    seq_ticks       = '0;
    seq_reached     = 1'b0;
    seq_clear       = 1'b1;
    seq_prev_target = '0;
    seq_lift        = sfs_pkg::LIFT_OFF;
    seq_drive       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(sfs_pkg::OP_ALL_OFF, 15'd0, 16'd0, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(OP_SPARE_5, 15'h7FFF, 16'hFFFF, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(OP_SPARE_6, 15'd0, 16'd0, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(OP_SPARE_7, 15'h7FFF, 16'hFFFF, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(sfs_pkg::OP_HOLD_SPEED, 15'h7FFF, 16'd0, 1,
            sfs_pkg::LIFT_OFF, sfs_pkg::Q15_FULL, 0, 1);
    add_row(sfs_pkg::OP_HOLD_SPEED, 15'd0, 16'hFFFF, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(sfs_pkg::OP_SHOOT, 15'h7FFF, 16'hFFFF, 1,
            sfs_pkg::LIFT_OFF, sfs_pkg::Q15_FULL, 1, 1);
    add_row(sfs_pkg::OP_SHOOT, 15'h7FFF, 16'hFFFF, 1,
            sfs_pkg::LIFT_FORWARD, sfs_pkg::Q15_FULL, 1, 1);
    add_row(sfs_pkg::OP_SHOOT, 15'd16384, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd16384, 16'd13107, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd16384, 16'd13108, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd16384, 16'd13108, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_HOLD_SPEED, 15'd1000, 16'd500, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_ALL_OFF, 15'd0, 16'd0, 1, sfs_pkg::LIFT_OFF, 16'd0, 1, 1);
    add_row(sfs_pkg::OP_NOT_SHOOTING, 15'd0, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_PRELOAD, 15'd0, 16'hFFFF, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(sfs_pkg::OP_PRELOAD, 15'd0, 16'd6554, 1, sfs_pkg::LIFT_OFF, 16'd0, 0, 1);
    add_row(sfs_pkg::OP_PRELOAD, 15'd0, 16'd6553, 1, sfs_pkg::LIFT_FORWARD, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd5000, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_HOLD_SPEED, 15'd5000, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd5000, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(OP_SPARE_5, 15'd0, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_NOT_SHOOTING, 15'd0, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    add_row(sfs_pkg::OP_SHOOT, 15'd0, 16'd0, 0, sfs_pkg::LIFT_OFF, 16'd0, 0, 0);
    foreach (opening_script[i]) begin
      send_tick(opening_script[i].stim, opening_script[i].typed, opening_script[i].want);
    end
    play_phase(120);
    play_phase(120);

    load_settings(16'd0, 16'd0, 16'd0, 16'h8001);
    play_phase(250);
    load_settings(16'hFFFF, 16'd3, 16'd10, 16'h7FFF);
    play_phase(250);
    load_settings(16'h0080, 16'hFFFF, 16'd5, 16'hC000);
    play_phase(200);
    load_settings(16'h0400, 16'd1, 16'hFFFF, 16'h4000);
    play_phase(200);
    repeat (3) begin
      load_settings(16'($urandom), 16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)),
                    16'($urandom_range(0, 65534) - 32767));
      play_phase(220);
    end

    // run the spin-up counter up, then enter clearing from a count past the clear length
    idle_on = 1'b0;
    load_settings(16'h0200, 16'd5, 16'hFFFF, 16'h1234);
    repeat (150) send_tick(make_tick(sfs_pkg::OP_SHOOT, 15'd20000, 16'd0));
    send_tick(make_tick(sfs_pkg::OP_PRELOAD, 15'd20000, 16'd0));
    repeat (8) send_tick(make_tick(sfs_pkg::OP_SHOOT, 15'd20000, 16'd0));
    wait_drained();
    idle_on = 1'b1;
    play_phase(100);

    repeat (10) @(posedge clk);
    if (owed_commands.size() != 0) begin
      $error("%0d result transfers never arrived", owed_commands.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
